// ===== src/bpe_pkg.sv =====
// package for the password shift register encoder: types, constants, microcode
package bpe_pkg;

    localparam int CHAR_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 8;
    localparam int PC_W      = 3;

    localparam logic [IDX_W-1:0] MAX_CHARS = 3'd6;
    localparam logic [IDX_W-1:0] IDX_TOP   = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_VALUE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET = 8'd1;

    localparam logic [BYTE_W-1:0] SEED_RESET   = 8'hF0;
    localparam logic [BYTE_W-1:0] OFFSET_RESET = 8'd123;

    // feedback taps: bits 7, 6, 1 and 0
    localparam logic [BYTE_W-1:0] TAP_MASK = 8'h80 | 8'h40 | 8'h02 | 8'h01;

    // character ranges
    localparam logic [CHAR_W-1:0] LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP  = 8'h20;
    localparam logic [CHAR_W-1:0] DIGIT_0   = 8'h30;
    localparam logic [CHAR_W-1:0] DIGIT_9   = 8'h39;
    localparam logic [CHAR_W-1:0] UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z   = 8'h5A;

    // scan codes
    localparam logic [BYTE_W-1:0] DIGIT_CODES [10] = '{
        8'h0B, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A
    };
    localparam logic [BYTE_W-1:0] LETTER_CODES [26] = '{
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17,
        8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13,
        8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C
    };

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] code;
    } lookup_t;

    // fold to upper case and map to scan code
    function automatic lookup_t scan_lookup(input logic [CHAR_W-1:0] c_in);
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] rel;
        lookup_t           r;
        c = c_in;
        r = '0;
        if (c inside {[LOWER_A:LOWER_Z]})
            c = c - CASE_GAP;
        if (c inside {[DIGIT_0:DIGIT_9]})
        begin
            r.valid = 1'b1;
            r.code  = DIGIT_CODES[c[3:0]];
        end
        else if (c inside {[UPPER_A:UPPER_Z]})
        begin
            rel     = c - UPPER_A;
            r.valid = 1'b1;
            r.code  = LETTER_CODES[rel[4:0]];
        end
        return r;
    endfunction

    // one shift register step
    function automatic logic [BYTE_W-1:0] lfsr_step(input logic [BYTE_W-1:0] r);
        return {^(r & TAP_MASK), r[BYTE_W-1:1]};
    endfunction

    // microcode
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_START,
        C_CNT_ZERO,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_SEED,
        OP_DECODE,
        OP_STEP,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic            in_ready;
        cond_t           cond;
        logic [PC_W-1:0] pc_true;
        logic [PC_W-1:0] pc_false;
        op_t             op;
    } ctrl_t;

    localparam logic [PC_W-1:0] PC_FETCH  = 3'd0;
    localparam logic [PC_W-1:0] PC_START  = 3'd1;
    localparam logic [PC_W-1:0] PC_SEED   = 3'd2;
    localparam logic [PC_W-1:0] PC_DECODE = 3'd3;
    localparam logic [PC_W-1:0] PC_STEP   = 3'd4;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd5;

    // control store
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            PC_FETCH:  w = '{1'b1, C_ACCEPT,   PC_START,  PC_FETCH,  OP_LATCH};
            PC_START:  w = '{1'b0, C_START,    PC_SEED,   PC_DECODE, OP_NONE};
            PC_SEED:   w = '{1'b0, C_OUT_FREE, PC_DECODE, PC_SEED,   OP_SEED};
            PC_DECODE: w = '{1'b0, C_ALWAYS,   PC_STEP,   PC_STEP,   OP_DECODE};
            PC_STEP:   w = '{1'b0, C_CNT_ZERO, PC_EMIT,   PC_STEP,   OP_STEP};
            PC_EMIT:   w = '{1'b0, C_OUT_FREE, PC_FETCH,  PC_EMIT,   OP_EMIT};
            default:   w = '{1'b0, C_ALWAYS,   PC_FETCH,  PC_FETCH,  OP_NONE};
        endcase
        return w;
    endfunction

endpackage

// ===== src/bpe_if.sv =====
// valid/ready channel interfaces for characters, encoded bytes and configuration
interface bpe_char_if;
    logic                       valid;
    logic                       ready;
    logic [bpe_pkg::CHAR_W-1:0] char_code;
    logic                       end_of_password;

    modport source (output valid, output char_code, output end_of_password, input ready);
    modport sink (input valid, input char_code, input end_of_password, output ready);
endinterface

interface bpe_code_if;
    logic                       valid;
    logic                       ready;
    logic [bpe_pkg::BYTE_W-1:0] enc_byte;
    logic                       bad_char;
    logic                       last_of_run;

    modport source (output valid, output enc_byte, output bad_char, output last_of_run,
                    input ready);
    modport sink (input valid, input enc_byte, input bad_char, input last_of_run,
                  output ready);
endinterface

interface bpe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bpe_pkg::CFG_IDX_W-1:0] index;
    logic [bpe_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/bios_password_lfsr_encoder.sv =====
// password encoder: microcoded sequencer stepping an 8-bit feedback shift register
// Flow: a new character is taken only in fetch, after the result of the last one is emitted;
//   count is the step count (0..255), one shift register step per cycle in the step loop.
// Results are registered; at the start of a password the seed is emitted first, then the
//   character result follows decode, the step loop and emit.
// Reset: asynchronous, active low; seed 0xF0, offset 123, sequencer at fetch, no results.
module bios_password_lfsr_encoder (
    input logic      clk,
    input logic      rst_n,
    bpe_char_if.sink chars,
    bpe_code_if.source codes,
    bpe_cfg_if.sink  cfg
);
    import bpe_pkg::*;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [BYTE_W-1:0] seed_reg, seed_next;
    logic [BYTE_W-1:0] offset_reg, offset_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [BYTE_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              start_reg, start_next;
    logic              bad_reg, bad_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              eop_reg, eop_next;
    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic              obad_reg, obad_next;
    logic              olast_reg, olast_next;

    ctrl_t   cw;
    logic    cond_hit;
    logic    in_xfer;
    logic    out_free;
    lookup_t lk;
    logic    dec_bad;

    // control word fetch and condition select
    assign cw       = ucode(pc_reg);
    assign in_xfer  = chars.valid && cw.in_ready;
    assign out_free = !ovalid_reg || codes.ready;
    assign lk       = scan_lookup(char_reg);
    assign dec_bad  = !lk.valid || (idx_reg >= MAX_CHARS);

    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_ACCEPT:   cond_hit = in_xfer;
            C_START:    cond_hit = start_reg;
            C_CNT_ZERO: cond_hit = (cnt_reg == '0);
            C_OUT_FREE: cond_hit = out_free;
            default:    cond_hit = 1'b1;
        endcase
    end

    assign pc_next = cond_hit ? cw.pc_true : cw.pc_false;

    // configuration writes
    always_comb
    begin
        seed_next   = seed_reg;
        offset_next = offset_reg;
        if (cfg.valid)
        begin
            if (cfg.index == CFG_SEED_VALUE)
                seed_next = cfg.data;
            else if (cfg.index == CFG_FIRST_OFFSET)
                offset_next = cfg.data;
        end
    end

    // datapath driven by the control word
    always_comb
    begin
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        bad_next    = bad_reg;
        char_next   = char_reg;
        eop_next    = eop_reg;
        ovalid_next = ovalid_reg && !codes.ready;
        obyte_next  = obyte_reg;
        obad_next   = obad_reg;
        olast_next  = olast_reg;
        case (cw.op)
            OP_LATCH:
            begin
                if (in_xfer)
                begin
                    char_next = chars.char_code;
                    eop_next  = chars.end_of_password;
                end
            end
            OP_SEED:
            begin
                if (out_free)
                begin
                    shift_next  = seed_reg;
                    idx_next    = '0;
                    start_next  = 1'b0;
                    ovalid_next = 1'b1;
                    obyte_next  = seed_reg;
                    obad_next   = 1'b0;
                    olast_next  = 1'b0;
                end
            end
            OP_DECODE:
            begin
                bad_next = dec_bad;
                if (dec_bad)
                    cnt_next = '0;
                else if (idx_reg == '0)
                    cnt_next = lk.code + offset_reg;
                else
                    cnt_next = lk.code;
            end
            OP_STEP:
            begin
                if (cnt_reg != '0)
                begin
                    shift_next = lfsr_step(shift_reg);
                    cnt_next   = cnt_reg - 8'd1;
                end
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = shift_reg;
                    obad_next   = bad_reg;
                    olast_next  = 1'b1;
                    if (eop_reg)
                    begin
                        idx_next   = '0;
                        start_next = 1'b1;
                    end
                    else if (idx_reg != IDX_TOP)
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= PC_FETCH;
            seed_reg   <= SEED_RESET;
            offset_reg <= OFFSET_RESET;
            shift_reg  <= SEED_RESET;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            start_reg  <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            seed_reg   <= seed_next;
            offset_reg <= offset_next;
            shift_reg  <= shift_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            start_reg  <= start_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bad_reg   <= bad_next;
        char_reg  <= char_next;
        eop_reg   <= eop_next;
        obyte_reg <= obyte_next;
        obad_reg  <= obad_next;
        olast_reg <= olast_next;
    end

    // ports
    assign chars.ready       = cw.in_ready;
    assign cfg.ready         = 1'b1;
    assign codes.valid       = ovalid_reg;
    assign codes.enc_byte    = obyte_reg;
    assign codes.bad_char    = obad_reg;
    assign codes.last_of_run = olast_reg;

`ifndef ASSERT_OFF
    // sequencer stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_EMIT)
        else $error("sequencer left the program");

    // an input transfer moves on to the start check
    a_fetch_adv: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.ready |=> pc_reg == PC_START)
        else $error("input transfer did not advance the sequencer");

    // each step with a nonzero count counts down by one
    a_step_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == PC_STEP && cnt_reg != '0 |=> cnt_reg == $past(cnt_reg) - 8'd1)
        else $error("step counter did not count down");

    // seed result carries the loaded register value and is not the last one
    a_seed_out: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == PC_SEED && out_free |=>
            codes.valid && !codes.last_of_run && codes.enc_byte == shift_reg)
        else $error("seed result does not match the register");

    // input is taken only when no result is pending inside the sequencer
    a_ready_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        chars.ready |-> pc_reg == PC_FETCH)
        else $error("input ready outside fetch");
`endif

endmodule
